FILE: rtl/core/baro_pressure_temp_compensation_assert.svh
// Assertion helpers for the barometer compensation block
`ifndef BARO_PRESSURE_TEMP_COMPENSATION_ASSERT_SVH
`define BARO_PRESSURE_TEMP_COMPENSATION_ASSERT_SVH

`ifndef SYNTHESIS
// clocked check, off while reset is active
`define BPTC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// clocked check, also during reset
`define BPTC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define BPTC_ASSERT(lbl, prop, msg)
`define BPTC_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

FILE: rtl/core/bptc_pkg.sv
`default_nettype none
package bptc_pkg;

  localparam int QW      = 64;   // fixed-point word
  localparam int MAG_W   = 62;   // magnitude bits of a clamped value
  localparam int PROD_W  = 124;  // full product of two magnitudes
  localparam int CNT_W   = 7;    // iteration counter
  localparam int SCALE_W = 23;   // widest scale factor
  localparam int PC_W    = 5;

  localparam logic signed [QW-1:0] QLIM = 64'sh3FFF_FFFF_FFFF_FFFF;

  localparam logic [PC_W-1:0] PC_PRES = 5'd0;
  localparam logic [PC_W-1:0] PC_TEMP = 5'd16;
  localparam logic [PC_W-1:0] PC_LAST = 5'd19;

  typedef enum logic [1:0] {ST_IDLE, ST_ISSUE, ST_ARITH} state_e;

  typedef enum logic [1:0] {OP_DIV, OP_MUL, OP_ADD, OP_FIN} op_e;

  typedef enum logic [3:0] {
    S_PSC, S_TSC, S_A, S_B, S_D, S_C00, S_C10, S_C01,
    S_C11, S_C20, S_C21, S_C30, S_C0H, S_C1, S_RAWP, S_RAWT
  } src_e;

  typedef enum logic [2:0] {D_PSC, D_TSC, D_A, D_B, D_D, D_NONE} dst_e;

  typedef enum logic [2:0] {
    REG_TEMP_COEF, REG_OFFSET_COEF, REG_C01, REG_C11,
    REG_C20, REG_C21, REG_C30, REG_OSR
  } cfg_reg_e;

  typedef struct packed {
    op_e  op;
    src_e sa;
    src_e sb;
    dst_e dst;
  } instr_t;

  typedef struct packed {
    logic start;
    logic is_div;
  } arith_req_t;

  typedef struct packed {
    logic done;
    logic clamp;
  } arith_rsp_t;

  // scale factor per oversampling code
  function automatic logic [SCALE_W-1:0] scale_lookup(logic [2:0] code);
    logic [SCALE_W-1:0] s;
    unique case (code)
      3'd0: s = 23'd524288;
      3'd1: s = 23'd1572864;
      3'd2: s = 23'd3670016;
      3'd3: s = 23'd7864320;
      3'd4: s = 23'd253952;
      3'd5: s = 23'd516096;
      3'd6: s = 23'd1040384;
      3'd7: s = 23'd2088960;
    endcase
    return s;
  endfunction

  // microprogram: pressure from PC_PRES, temperature from PC_TEMP
  function automatic instr_t fetch(logic [PC_W-1:0] pc);
    instr_t i;
    case (pc)
      5'd0:  i = '{OP_DIV, S_RAWP, S_RAWP, D_PSC};
      5'd1:  i = '{OP_DIV, S_RAWT, S_RAWT, D_TSC};
      5'd2:  i = '{OP_MUL, S_PSC,  S_C30,  D_A};
      5'd3:  i = '{OP_ADD, S_C20,  S_A,    D_A};
      5'd4:  i = '{OP_MUL, S_PSC,  S_A,    D_A};
      5'd5:  i = '{OP_ADD, S_C10,  S_A,    D_A};
      5'd6:  i = '{OP_MUL, S_PSC,  S_A,    D_A};
      5'd7:  i = '{OP_ADD, S_C00,  S_A,    D_A};
      5'd8:  i = '{OP_MUL, S_TSC,  S_C01,  D_B};
      5'd9:  i = '{OP_ADD, S_A,    S_B,    D_A};
      5'd10: i = '{OP_MUL, S_PSC,  S_C21,  D_B};
      5'd11: i = '{OP_ADD, S_C11,  S_B,    D_B};
      5'd12: i = '{OP_MUL, S_TSC,  S_PSC,  D_D};
      5'd13: i = '{OP_MUL, S_D,    S_B,    D_D};
      5'd14: i = '{OP_ADD, S_A,    S_D,    D_A};
      5'd15: i = '{OP_FIN, S_A,    S_A,    D_NONE};
      5'd16: i = '{OP_DIV, S_RAWT, S_RAWT, D_TSC};
      5'd17: i = '{OP_MUL, S_TSC,  S_C1,   D_A};
      5'd18: i = '{OP_ADD, S_C0H,  S_A,    D_A};
      default: i = '{OP_FIN, S_A, S_A, D_NONE};
    endcase
    return i;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/bptc_arith.sv
`default_nettype none
// Bit-serial unit: restoring divider (raw << frac / scale) and
// shift-add multiplier with truncation to frac bits and clamping.
module bptc_arith #(
  parameter int RAW_WIDTH        = 24,
  parameter int SCALED_FRAC_BITS = 24
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire bptc_pkg::arith_req_t            req_i,
  input  wire logic signed [63:0]              opa_i,
  input  wire logic signed [63:0]              opb_i,
  input  wire logic signed [RAW_WIDTH-1:0]     div_raw_i,
  input  wire logic [bptc_pkg::SCALE_W-1:0]    div_scale_i,
  output bptc_pkg::arith_rsp_t                 rsp_o,
  output logic signed [63:0]                   result_o
);
  import bptc_pkg::*;

  localparam int NB = RAW_WIDTH + SCALED_FRAC_BITS;
  localparam int F  = SCALED_FRAC_BITS;

  logic              busy_q, busy_d;
  logic              is_div_q, is_div_d;
  logic              neg_q, neg_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [QW-1:0]     sh_q, sh_d;
  logic [MAG_W-1:0]  x_q, x_d;
  logic [PROD_W-1:0] acc_q, acc_d;

  logic signed [QW-1:0] raw_ext, raw_mag, a_mag, b_mag;
  logic [SCALE_W:0]     rem_x, rem_n;
  logic                 ge;
  logic [MAG_W:0]       sum;
  logic                 ovf;
  logic [QW-1:0]        qv;

  assign raw_ext = QW'(div_raw_i);
  assign raw_mag = raw_ext[QW-1] ? -raw_ext : raw_ext;
  assign a_mag   = opa_i[QW-1] ? -opa_i : opa_i;
  assign b_mag   = opb_i[QW-1] ? -opb_i : opb_i;

  // one divider step and one multiplier step
  assign rem_x = {acc_q[SCALE_W-1:0], sh_q[NB-1]};
  assign ge    = rem_x >= {1'b0, x_q[SCALE_W-1:0]};
  assign rem_n = ge ? rem_x - {1'b0, x_q[SCALE_W-1:0]} : rem_x;
  assign sum   = {1'b0, acc_q[PROD_W-1:MAG_W]} + (sh_q[0] ? {1'b0, x_q} : '0);

  always_comb begin
    busy_d   = busy_q;
    is_div_d = is_div_q;
    neg_d    = neg_q;
    cnt_d    = cnt_q;
    sh_d     = sh_q;
    x_d      = x_q;
    acc_d    = acc_q;
    if (req_i.start) begin
      busy_d   = 1'b1;
      is_div_d = req_i.is_div;
      acc_d    = '0;
      if (req_i.is_div) begin
        neg_d = raw_ext[QW-1];
        cnt_d = CNT_W'(NB);
        sh_d  = raw_mag << F;
        x_d   = MAG_W'(div_scale_i);
      end else begin
        neg_d = opa_i[QW-1] ^ opb_i[QW-1];
        cnt_d = CNT_W'(MAG_W);
        sh_d  = QW'(b_mag[MAG_W-1:0]);
        x_d   = a_mag[MAG_W-1:0];
      end
    end else if (busy_q) begin
      if (cnt_q != '0) begin
        cnt_d = cnt_q - 1'b1;
        if (is_div_q) begin
          acc_d = PROD_W'(rem_n[SCALE_W-1:0]);
          sh_d  = {sh_q[QW-2:0], ge};
        end else begin
          acc_d = {sum, acc_q[MAG_W-1:1]};
          sh_d  = sh_q >> 1;
        end
      end else begin
        busy_d = 1'b0;
      end
    end
  end

  // result from the final register contents
  assign ovf = |acc_q[PROD_W-1:MAG_W+F];
  always_comb begin
    if (is_div_q) begin
      qv = QW'(sh_q[NB-1:0]);
    end else if (ovf) begin
      qv = QLIM;
    end else begin
      qv = QW'(acc_q[F +: MAG_W]);
    end
    result_o = neg_q ? -$signed(qv) : $signed(qv);
  end

  assign rsp_o.done  = busy_q && (cnt_q == '0);
  assign rsp_o.clamp = !is_div_q && ovf;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      is_div_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      busy_q   <= busy_d;
      is_div_q <= is_div_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q <= neg_d;
    sh_q  <= sh_d;
    x_q   <= x_d;
    acc_q <= acc_d;
  end

endmodule
`default_nettype wire

FILE: rtl/core/baro_pressure_temp_compensation.sv
`default_nettype none
// Channel   Dir  tdata (low bit up)     tuser (low bit up)
// s_axis    in   raw_sample             func
// m_axis    out  value                  is_pressure, saturated
// cfg       in   write: cfg_we_i, cfg_idx_i, cfg_wdata_i
//
// One item at a time through a microcoded sequencer around a bit-serial
// divide/multiply unit, one bit per cycle; adds, the final step and the accept
// are handled by the sequencer itself. A temperature item runs one divide, one
// multiply and one add; a pressure item runs two divides, seven multiplies and
// six adds; both end in the final step.
// Reset is asynchronous, active low; no clearing pass.
// A new beat is taken while a finished result waits on m_axis; the
// sequencer holds its last step only while that output register is full.
module baro_pressure_temp_compensation #(
  parameter int RAW_WIDTH        = 24,
  parameter int SCALED_FRAC_BITS = 24
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  input  wire logic [((RAW_WIDTH+7)/8)*8-1:0]    s_axis_tdata,  // raw_sample
  input  wire logic                              s_axis_tuser,  // func
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  output logic [31:0]                            m_axis_tdata,  // value
  output logic [1:0]                             m_axis_tuser,  // is_pressure, saturated
  input  wire logic                              cfg_we_i,
  input  wire logic [2:0]                        cfg_idx_i,
  input  wire logic [39:0]                       cfg_wdata_i
);
  import bptc_pkg::*;

  localparam int F = SCALED_FRAC_BITS;

  // configuration
  logic [23:0] temp_coef_q;
  logic [39:0] off_coef_q;
  logic [15:0] c01_q, c11_q, c20_q, c21_q, c30_q;
  logic [5:0]  osr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      temp_coef_q <= '0;
      off_coef_q  <= '0;
      c01_q       <= '0;
      c11_q       <= '0;
      c20_q       <= '0;
      c21_q       <= '0;
      c30_q       <= '0;
      osr_q       <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_TEMP_COEF:   temp_coef_q <= cfg_wdata_i[23:0];
        REG_OFFSET_COEF: off_coef_q  <= cfg_wdata_i;
        REG_C01:         c01_q       <= cfg_wdata_i[15:0];
        REG_C11:         c11_q       <= cfg_wdata_i[15:0];
        REG_C20:         c20_q       <= cfg_wdata_i[15:0];
        REG_C21:         c21_q       <= cfg_wdata_i[15:0];
        REG_C30:         c30_q       <= cfg_wdata_i[15:0];
        REG_OSR:         osr_q       <= cfg_wdata_i[5:0];
      endcase
    end
  end

  // coefficients in fixed point
  logic signed [QW-1:0] c00q, c10q, c01q, c11q, c20q, c21q, c30q, c0h, c1q;
  assign c00q = QW'($signed(off_coef_q[39:20])) <<< F;
  assign c10q = QW'($signed(off_coef_q[19:0])) <<< F;
  assign c01q = QW'($signed(c01_q)) <<< F;
  assign c11q = QW'($signed(c11_q)) <<< F;
  assign c20q = QW'($signed(c20_q)) <<< F;
  assign c21q = QW'($signed(c21_q)) <<< F;
  assign c30q = QW'($signed(c30_q)) <<< F;
  assign c0h  = QW'($signed(temp_coef_q[23:12])) <<< (F - 1);
  assign c1q  = QW'($signed(temp_coef_q[11:0])) <<< F;

  // sequencer and working registers
  state_e                       state_q, state_d;
  logic [PC_W-1:0]              pc_q;
  logic                         func_q, sat_q;
  logic signed [RAW_WIDTH-1:0]  raw_p_q, last_raw_t_q;
  logic signed [QW-1:0]         psc_q, tsc_q, a_q, b_q, d_q;
  logic                         out_valid_q;
  logic [31:0]                  out_data_q;
  logic [1:0]                   out_user_q;

  instr_t               ins;
  logic signed [QW-1:0] opa, opb, add_s, add_c, arith_res, wr_val, fin_v, fin_sh;
  logic                 add_clamp, fin_clip, wr_en, sat_set, pc_inc, out_load, out_free;
  logic                 in_acc;
  logic [31:0]          fin_val;
  arith_req_t           req;
  arith_rsp_t           rsp;

  assign ins      = fetch(pc_q);
  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign out_free = !out_valid_q || m_axis_tready;

  function automatic logic signed [QW-1:0] pick(src_e s);
    logic signed [QW-1:0] v;
    unique case (s)
      S_PSC:  v = psc_q;
      S_TSC:  v = tsc_q;
      S_A:    v = a_q;
      S_B:    v = b_q;
      S_D:    v = d_q;
      S_C00:  v = c00q;
      S_C10:  v = c10q;
      S_C01:  v = c01q;
      S_C11:  v = c11q;
      S_C20:  v = c20q;
      S_C21:  v = c21q;
      S_C30:  v = c30q;
      S_C0H:  v = c0h;
      S_C1:   v = c1q;
      S_RAWP: v = QW'(raw_p_q);
      S_RAWT: v = QW'(last_raw_t_q);
    endcase
    return v;
  endfunction

  // operand select, re-evaluated when any source register changes
  always_comb begin
    opa = pick(ins.sa);
    opb = pick(ins.sb);
  end

  // clamped add
  assign add_s     = opa + opb;
  assign add_clamp = (add_s > QLIM) || (add_s < -QLIM);
  assign add_c     = (add_s > QLIM) ? QLIM : ((add_s < -QLIM) ? -QLIM : add_s);

  // final rounding toward minus infinity and clip to 32 bits
  assign fin_sh = func_q ? (opa >>> (F - 6)) : (opa >>> (F - 8));
  assign fin_v  = fin_sh;
  always_comb begin
    fin_clip = 1'b0;
    fin_val  = fin_v[31:0];
    if (fin_v > 64'sh0000_0000_7FFF_FFFF) begin
      fin_clip = 1'b1;
      fin_val  = 32'h7FFF_FFFF;
    end else if (fin_v < -64'sh0000_0000_8000_0000) begin
      fin_clip = 1'b1;
      fin_val  = 32'h8000_0000;
    end
  end

  bptc_arith #(
    .RAW_WIDTH        (RAW_WIDTH),
    .SCALED_FRAC_BITS (SCALED_FRAC_BITS)
  ) u_arith (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req),
    .opa_i       (opa),
    .opb_i       (opb),
    .div_raw_i   ((ins.sa == S_RAWP) ? raw_p_q : last_raw_t_q),
    .div_scale_i (scale_lookup((ins.sa == S_RAWP) ? osr_q[2:0] : osr_q[5:3])),
    .rsp_o       (rsp),
    .result_o    (arith_res)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) state_d = ST_ISSUE;
      end
      ST_ISSUE: begin
        unique case (ins.op)
          OP_DIV, OP_MUL: state_d = ST_ARITH;
          OP_ADD:         state_d = ST_ISSUE;
          OP_FIN:         if (out_free) state_d = ST_IDLE;
        endcase
      end
      ST_ARITH: begin
        if (rsp.done) state_d = ST_ISSUE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    s_axis_tready = (state_q == ST_IDLE);
    req.start     = 1'b0;
    req.is_div    = (ins.op == OP_DIV);
    wr_en         = 1'b0;
    wr_val        = add_c;
    sat_set       = 1'b0;
    pc_inc        = 1'b0;
    out_load      = 1'b0;
    unique case (state_q)
      ST_ISSUE: begin
        unique case (ins.op)
          OP_DIV, OP_MUL: req.start = 1'b1;
          OP_ADD: begin
            wr_en   = 1'b1;
            sat_set = add_clamp;
            pc_inc  = 1'b1;
          end
          OP_FIN: out_load = out_free;
        endcase
      end
      ST_ARITH: begin
        if (rsp.done) begin
          wr_en   = 1'b1;
          wr_val  = arith_res;
          sat_set = rsp.clamp;
          pc_inc  = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      pc_q         <= PC_PRES;
      out_valid_q  <= 1'b0;
      last_raw_t_q <= '0;
    end else begin
      state_q <= state_d;
      if (in_acc) begin
        pc_q <= s_axis_tuser ? PC_PRES : PC_TEMP;
        if (!s_axis_tuser) last_raw_t_q <= s_axis_tdata[RAW_WIDTH-1:0];
      end else if (pc_inc) begin
        pc_q <= pc_q + 1'b1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      func_q <= s_axis_tuser;
      sat_q  <= 1'b0;
      if (s_axis_tuser) raw_p_q <= s_axis_tdata[RAW_WIDTH-1:0];
    end else if (sat_set) begin
      sat_q <= 1'b1;
    end
    if (wr_en) begin
      unique case (ins.dst)
        D_PSC:   psc_q <= wr_val;
        D_TSC:   tsc_q <= wr_val;
        D_A:     a_q   <= wr_val;
        D_B:     b_q   <= wr_val;
        D_D:     d_q   <= wr_val;
        default: ;
      endcase
    end
    if (out_load) begin
      out_data_q <= fin_val;
      out_user_q <= {sat_q | fin_clip, func_q};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

`include "baro_pressure_temp_compensation_assert.svh"

`BPTC_ASSERT(a_done_in_arith, rsp.done |-> (state_q == ST_ARITH), "arith done outside wait")
`BPTC_ASSERT(a_no_overwrite, out_load |-> (!out_valid_q || m_axis_tready), "result overwritten")
`BPTC_ASSERT(a_accept_issue, in_acc |=> (state_q == ST_ISSUE), "accept did not start program")
`BPTC_ASSERT(a_pc_range, (state_q != ST_IDLE) |-> (pc_q <= PC_LAST), "program counter out of range")

endmodule
`default_nettype wire
